### sv/lba_pkg.sv
// ----------------------------------------------------------------------------
// lba_pkg
// Shared types and constants of the line block averager: register map,
// register reset values, controller states and the command and status groups
// that pass between controller and datapath.
// ----------------------------------------------------------------------------
package lba_pkg;

	localparam int SAMPLE_W = 8;
	localparam int SAT_MAX  = 255;

	// register map
	localparam int ADDR_W   = 4;
	localparam int LTA_RAW_W = 5;
	localparam int SPL_RAW_W = 11;
	localparam int LPF_RAW_W = 12;

	localparam logic [1:0] REG_LTA = 2'd0;
	localparam logic [1:0] REG_SPL = 2'd1;
	localparam logic [1:0] REG_LPF = 2'd2;

	localparam logic [LTA_RAW_W-1:0] LTA_RESET = 5'd2;
	localparam logic [SPL_RAW_W-1:0] SPL_RESET = 11'd512;
	localparam logic [LPF_RAW_W-1:0] LPF_RESET = 12'd256;

	// frame line counting
	localparam int LPF_MAX = 2048;
	localparam int LPF_W   = 12;
	localparam int LIF_W   = 11;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_FL_DIV,
		ST_FL_MUL,
		ST_IDLE,
		ST_SUM,
		ST_AVG_DIV,
		ST_EMIT
	} lba_state_t;

	typedef struct packed {
		logic fl_start;
		logic fl_load;
		logic accept;
		logic sum;
		logic load_out;
	} lba_cmd_t;

	typedef struct packed {
		logic div_done;
		logic emit;
		logic out_free;
	} lba_sts_t;

endpackage

### sv/lba_div.sv
// ----------------------------------------------------------------------------
// lba_div
// Restoring divider, one quotient bit per cycle. Serves both the full-block
// line count of a frame and the per-sample average.
// ----------------------------------------------------------------------------
module lba_div #(
	parameter int DIV_W = 12,
	parameter int DSR_W = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DSR_W-1:0] divisor,
	output logic             done,
	output logic [DIV_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic [DIV_W-1:0] quo_q;
	logic [DSR_W-1:0] rem_q;
	logic [DSR_W-1:0] dsr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DSR_W:0]   trial;
	logic             ge;
	logic [DSR_W:0]   diff;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign ge    = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], ge};
			rem_q <= ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### sv/lba_ctrl.sv
// ----------------------------------------------------------------------------
// lba_ctrl
// Controller: recomputes the full-block line count after reset and after
// each register write, then takes samples one at a time through accumulate
// and, on the last line of a full block, divide and output load.
// ----------------------------------------------------------------------------
module lba_ctrl
	import lba_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_wr,
	input  logic     sample_valid,
	output logic     sample_stall,
	input  lba_sts_t sts,
	output lba_cmd_t cmd
);

	lba_state_t state_q;
	lba_state_t state_d;
	logic       pend_q;
	logic       ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= cfg_wr | (pend_q & (state_q != ST_INIT));
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT:    state_d = ST_FL_DIV;
			ST_FL_DIV:  if (sts.div_done) state_d = ST_FL_MUL;
			ST_FL_MUL:  state_d = ST_IDLE;
			ST_IDLE: begin
				if (pend_q)
					state_d = ST_INIT;
				else if (sample_valid)
					state_d = ST_SUM;
			end
			ST_SUM:     state_d = sts.emit ? ST_AVG_DIV : ST_IDLE;
			ST_AVG_DIV: if (sts.div_done) state_d = ST_EMIT;
			ST_EMIT:    if (sts.out_free) state_d = ST_IDLE;
			default:    state_d = ST_INIT;
		endcase
	end

	always_comb begin
		cmd   = '0;
		ready = 1'b0;
		case (state_q)
			ST_INIT:   cmd.fl_start = 1'b1;
			ST_FL_MUL: cmd.fl_load  = 1'b1;
			ST_IDLE: begin
				ready      = !pend_q;
				cmd.accept = !pend_q && sample_valid;
			end
			ST_SUM:    cmd.sum      = 1'b1;
			ST_EMIT:   cmd.load_out = sts.out_free;
			default:   ready        = 1'b0;
		endcase
	end

	assign sample_stall = !ready;

endmodule

### sv/lba_dp.sv
// ----------------------------------------------------------------------------
// lba_dp
// Datapath: position and line counters, per-position accumulator memory,
// shared divider, saturation and output register.
// ----------------------------------------------------------------------------
module lba_dp
	import lba_pkg::*;
#(
	parameter int MAX_SAMPLES = 1024,
	parameter int MAX_LINES   = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  lba_cmd_t                             cmd,
	output lba_sts_t                             sts,
	input  logic [SAMPLE_W-1:0]                  sample,
	input  logic [$clog2(MAX_LINES+1)-1:0]       lta,
	input  logic [$clog2(MAX_SAMPLES+1)-1:0]     spl,
	input  logic [LPF_W-1:0]                     lpf,
	input  logic                                 avg_stall,
	output logic                                 avg_valid,
	output logic [SAMPLE_W-1:0]                  avg_sample,
	output logic                                 line_end,
	output logic                                 frame_end
);

	localparam int POS_W = $clog2(MAX_SAMPLES);
	localparam int LIB_W = $clog2(MAX_LINES);
	localparam int LTA_W = $clog2(MAX_LINES + 1);
	localparam int SUM_W = SAMPLE_W + $clog2(MAX_LINES);
	localparam int DIV_W = (SUM_W > LPF_W) ? SUM_W : LPF_W;
	localparam int PRD_W = DIV_W + LTA_W;

	logic [POS_W-1:0]    pos_q;
	logic [LIB_W-1:0]    lib_q;
	logic [LIF_W-1:0]    lif_q;
	logic [LPF_W-1:0]    full_lines_q;

	logic [SUM_W-1:0]    mem [MAX_SAMPLES];
	logic [SUM_W-1:0]    rd_s1;
	logic [POS_W-1:0]    addr_s1;
	logic [SAMPLE_W-1:0] smp_s1;
	logic                first_s1;
	logic                emit_s1;
	logic                le_s1;
	logic                fe_s1;

	logic                avg_valid_q;
	logic [SAMPLE_W-1:0] avg_q;
	logic                le_q;
	logic                fe_q;

	logic [POS_W:0]      pos_inc;
	logic [LIB_W:0]      lib_inc;
	logic [LPF_W-1:0]    lif_inc;
	logic                last_sample;
	logic                last_lob;
	logic                last_lof;
	logic                emit;
	logic                fe;
	logic [SUM_W-1:0]    sum;

	logic                div_start;
	logic [DIV_W-1:0]    div_dividend;
	logic                div_done;
	logic [DIV_W-1:0]    div_quo;
	logic [PRD_W-1:0]    fl_prod;
	logic [SAMPLE_W-1:0] avg_sat;

	assign pos_inc     = (POS_W+1)'(pos_q) + 1'b1;
	assign lib_inc     = (LIB_W+1)'(lib_q) + 1'b1;
	assign lif_inc     = LPF_W'(lif_q) + 1'b1;
	assign last_sample = pos_inc >= (POS_W+1)'(spl);
	assign last_lob    = lib_inc >= (LIB_W+1)'(lta);
	assign last_lof    = lif_inc >= lpf;
	assign emit        = last_lob && (LPF_W'(lif_q) < full_lines_q);
	assign fe          = last_sample && (lif_inc >= full_lines_q);

	// load the full-block line count and advance the position and line counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			lib_q        <= '0;
			lif_q        <= '0;
			full_lines_q <= '0;
		end else begin
			if (cmd.fl_load)
				full_lines_q <= fl_prod[LPF_W-1:0];
			if (cmd.accept) begin
				if (last_sample) begin
					pos_q <= '0;
					if (last_lof) begin
						lif_q <= '0;
						lib_q <= '0;
					end else begin
						lif_q <= lif_q + 1'b1;
						lib_q <= last_lob ? '0 : lib_q + 1'b1;
					end
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			addr_s1  <= pos_q;
			smp_s1   <= sample;
			first_s1 <= (lib_q == '0);
			emit_s1  <= emit;
			le_s1    <= last_sample;
			fe_s1    <= fe;
		end
	end

	assign sum = first_s1 ? SUM_W'(smp_s1) : rd_s1 + SUM_W'(smp_s1);

	always_ff @(posedge clk) begin
		if (cmd.accept)
			rd_s1 <= mem[pos_q];
		if (cmd.sum)
			mem[addr_s1] <= sum;
	end

	assign div_start    = cmd.fl_start | (cmd.sum & emit_s1);
	assign div_dividend = cmd.fl_start ? DIV_W'(lpf) : DIV_W'(sum);

	lba_div #(
		.DIV_W(DIV_W),
		.DSR_W(LTA_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (lta),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign fl_prod = PRD_W'(div_quo) * PRD_W'(lta);
	assign avg_sat = (div_quo > DIV_W'(SAT_MAX)) ? SAMPLE_W'(SAT_MAX) : div_quo[SAMPLE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out)
				avg_valid_q <= 1'b1;
			else if (!avg_stall)
				avg_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			avg_q <= avg_sat;
			le_q  <= le_s1;
			fe_q  <= fe_s1;
		end
	end

	assign sts.div_done = div_done;
	assign sts.emit     = emit_s1;
	assign sts.out_free = !avg_valid_q || !avg_stall;

	assign avg_valid  = avg_valid_q;
	assign avg_sample = avg_q;
	assign line_end   = le_q;
	assign frame_end  = fe_q;

endmodule

### sv/line_block_averager.sv
// ----------------------------------------------------------------------------
// line_block_averager
// Averages blocks of consecutive echo lines position by position and emits
// one averaged line per full block, with line and frame end marks.
// ----------------------------------------------------------------------------
// A sample on a line that does not end a block passes through accept, then
// accumulator read-modify-write. A sample on the last line of a full block
// also passes through a shared restoring divider, DIV_W bits wide, that
// yields one quotient bit per cycle, where DIV_W is the larger of 12 and
// 8 + clog2(MAX_LINES). After reset and after every register write the input
// stalls while the same divider recomputes the number of lines in full blocks
// of a frame. The accumulator is a MAX_SAMPLES-entry memory that needs no
// clearing, since the first line of each block overwrites it. A finished
// result waits in an output register while the next sample is taken.
// ----------------------------------------------------------------------------
module line_block_averager
	import lba_pkg::*;
#(
	parameter int MAX_SAMPLES = 1024,
	parameter int MAX_LINES   = 16
) (
	input  logic                clk,
	input  logic                arst_n,

	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,

	input  logic                sample_valid,
	output logic                sample_stall,
	input  logic [SAMPLE_W-1:0] sample,

	output logic                avg_valid,
	input  logic                avg_stall,
	output logic [SAMPLE_W-1:0] avg_sample,
	output logic                line_end,
	output logic                frame_end
);

	localparam int SPL_W = $clog2(MAX_SAMPLES + 1);
	localparam int LTA_W = $clog2(MAX_LINES + 1);

	logic [LTA_RAW_W-1:0] lta_raw_q;
	logic [SPL_RAW_W-1:0] spl_raw_q;
	logic [LPF_RAW_W-1:0] lpf_raw_q;

	logic                 cfg_wr;
	logic [LTA_W-1:0]     lta;
	logic [SPL_W-1:0]     spl;
	logic [LPF_W-1:0]     lpf;

	lba_cmd_t             cmd;
	lba_sts_t             sts;

	assign cfg_wr = psel & penable & pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lta_raw_q <= LTA_RESET;
			spl_raw_q <= SPL_RESET;
			lpf_raw_q <= LPF_RESET;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_LTA: lta_raw_q <= pwdata[LTA_RAW_W-1:0];
				REG_SPL: spl_raw_q <= pwdata[SPL_RAW_W-1:0];
				REG_LPF: lpf_raw_q <= pwdata[LPF_RAW_W-1:0];
				default: lta_raw_q <= lta_raw_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_LTA: prdata = 32'(lta_raw_q);
			REG_SPL: prdata = 32'(spl_raw_q);
			REG_LPF: prdata = 32'(lpf_raw_q);
			default: prdata = '0;
		endcase
	end

	// saturate registers to their working ranges
	assign lta = (lta_raw_q == '0) ? LTA_W'(1) :
		(32'(lta_raw_q) > 32'(MAX_LINES)) ? LTA_W'(MAX_LINES) : LTA_W'(lta_raw_q);
	assign spl = (spl_raw_q == '0) ? SPL_W'(1) :
		(32'(spl_raw_q) > 32'(MAX_SAMPLES)) ? SPL_W'(MAX_SAMPLES) : SPL_W'(spl_raw_q);
	assign lpf = (lpf_raw_q == '0) ? LPF_W'(1) :
		(32'(lpf_raw_q) > 32'(LPF_MAX)) ? LPF_W'(LPF_MAX) : LPF_W'(lpf_raw_q);

	lba_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr       (cfg_wr),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sts          (sts),
		.cmd          (cmd)
	);

	lba_dp #(
		.MAX_SAMPLES(MAX_SAMPLES),
		.MAX_LINES  (MAX_LINES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.sample     (sample),
		.lta        (lta),
		.spl        (spl),
		.lpf        (lpf),
		.avg_stall  (avg_stall),
		.avg_valid  (avg_valid),
		.avg_sample (avg_sample),
		.line_end   (line_end),
		.frame_end  (frame_end)
	);

endmodule
